// File: src/pfp_pkg.sv
package pfp_pkg;

    typedef enum logic [2:0] {
        FMT_ALPHA8   = 3'd0,
        FMT_RGBA4444 = 3'd1,
        FMT_ARGB1555 = 3'd2,
        FMT_RGB565   = 3'd3,
        FMT_ARGB4444 = 3'd4,
        FMT_RGB888   = 3'd5,
        FMT_RGBA8888 = 3'd6,
        FMT_ARGB8888 = 3'd7
    } t_format;

    localparam t_format FMT_RESET = FMT_RGBA8888;

    localparam logic [5:0] LVL_4B = 6'd15;
    localparam logic [5:0] LVL_5B = 6'd31;
    localparam logic [5:0] LVL_6B = 6'd63;

    localparam logic [2:0] CNT_1 = 3'd1;
    localparam logic [2:0] CNT_2 = 3'd2;
    localparam logic [2:0] CNT_3 = 3'd3;
    localparam logic [2:0] CNT_4 = 3'd4;

    typedef struct packed {
        logic [7:0] blue_in;
        logic [7:0] green_in;
        logic [7:0] red_in;
        logic [7:0] alpha_in;
        logic       end_of_image;
    } t_pixel_in;

    typedef struct packed {
        logic [31:0] packed_bytes;
        logic [2:0]  byte_count;
        logic        end_of_image_out;
    } t_pixel_out;

    // (x*m + 127) / 255, divide done as (v + (v >> 8) + 1) >> 8 (exact for v < 65535)
    function automatic logic [5:0] quant(input logic [7:0] x, input logic [5:0] m);
        logic [14:0] v;
        logic [14:0] t;
        v = 15'(x) * 15'(m) + 15'd127;
        t = v + 15'(v[14:8]) + 15'd1;
        return t[13:8];
    endfunction

endpackage

// File: src/pfp_pack.sv
module pfp_pack
    import pfp_pkg::*;
(
    input  t_format    i_format,
    input  t_pixel_in  i_pixel,
    output t_pixel_out o_result
);

    logic [7:0]  b, g, r, a;
    logic [5:0]  q_r4, q_g4, q_b4, q_a4;
    logic [5:0]  q_r5, q_g5, q_b5;
    logic [3:0]  r4, g4, b4, a4;
    logic [4:0]  r5, g5, b5;
    logic [5:0]  g6;
    logic        a1;
    logic [31:0] bytes;
    logic [2:0]  cnt;

    assign b = i_pixel.blue_in;
    assign g = i_pixel.green_in;
    assign r = i_pixel.red_in;
    assign a = i_pixel.alpha_in;

    // rgb565 red rounding (r*62+255)/510 matches the 5-bit narrowing
    always_comb begin
        q_r4 = quant(r, LVL_4B);
        q_g4 = quant(g, LVL_4B);
        q_b4 = quant(b, LVL_4B);
        q_a4 = quant(a, LVL_4B);
        q_r5 = quant(r, LVL_5B);
        q_g5 = quant(g, LVL_5B);
        q_b5 = quant(b, LVL_5B);
        r4 = q_r4[3:0];
        g4 = q_g4[3:0];
        b4 = q_b4[3:0];
        a4 = q_a4[3:0];
        r5 = q_r5[4:0];
        g5 = q_g5[4:0];
        b5 = q_b5[4:0];
        g6 = quant(g, LVL_6B);
        a1 = (a == 8'hff);
    end

    always_comb begin
        bytes = 32'd0;
        cnt   = CNT_2;
        case (i_format)
            FMT_ALPHA8: begin
                bytes = {24'd0, a};
                cnt   = CNT_1;
            end
            FMT_RGBA4444: begin
                bytes = {16'd0, r4, g4, b4, a4};
            end
            FMT_ARGB1555: begin
                bytes = {16'd0, a1, r5, g5, b5};
            end
            FMT_RGB565: begin
                bytes = {16'd0, r5, g6, b5};
            end
            FMT_ARGB4444: begin
                bytes = {16'd0, a4, r4, g4, b4};
            end
            FMT_RGB888: begin
                bytes = {8'd0, b, g, r};
                cnt   = CNT_3;
            end
            FMT_RGBA8888: begin
                bytes = {a, b, g, r};
                cnt   = CNT_4;
            end
            default: begin
                bytes = {b, g, r, a};
                cnt   = CNT_4;
            end
        endcase
    end

    assign o_result.packed_bytes     = bytes;
    assign o_result.byte_count       = cnt;
    assign o_result.end_of_image_out = i_pixel.end_of_image;

endmodule

// File: src/pixel_format_packer_unit.sv
// Pipeline: the pixel is registered in r_in at the accepting edge, converted by
// pfp_pack, and the beat is registered in r_out with its strobe in r_out_vld.
// Throughput: one pixel per cycle; busy is never raised and the result
// path has no backpressure, so every beat is registered in r_out after conversion.
// Reset (i_rst_n low, synchronous) clears the valid flags and sets the
// format register to rgba8888.
module pixel_format_packer_unit
    import pfp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_pixel_in  i_pixel,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_wdata,
    output logic       o_strobe,
    output t_pixel_out o_result
);

    t_format    r_format;
    logic       r_in_vld;
    t_pixel_in  r_in;
    logic       r_out_vld;
    t_pixel_out r_out;
    t_pixel_out n_out;
    logic       accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= FMT_RESET;
        end else if (i_cfg_we) begin
            r_format <= t_format'(i_cfg_wdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= accept;
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_pixel;
        end
        r_out <= n_out;
    end

    pfp_pack u_pack (
        .i_format (r_format),
        .i_pixel  (r_in),
        .o_result (n_out)
    );

    assign o_strobe = r_out_vld;
    assign o_result = r_out;

`ifndef SYNTH
    a_strobe_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ##1 o_strobe)
        else $error("accepted beat did not produce a result");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.byte_count >= CNT_1 && o_result.byte_count <= CNT_4))
        else $error("byte count out of range");

    a_unused_bytes_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.byte_count == CNT_2) |-> o_result.packed_bytes[31:16] == 16'd0)
        else $error("upper bytes not zero on a two byte beat");

    a_eoi_passes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ##1 (o_result.end_of_image_out == $past(i_pixel.end_of_image, 2)))
        else $error("end flag mismatch");
`endif

endmodule
